// ----- design/dmhq_pkg.sv -----
// dmhq_pkg: shared types and constants of the d-ary max heap queue
// field widths, request and status codes, controller states
// no dependencies
package dmhq_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int KEY_W    = 32;
    localparam int ARITY_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;
    localparam logic [ARITY_W-1:0] ARITY_MIN   = 4'd2;
    localparam logic [ARITY_W-1:0] ARITY_MAX   = 4'd8;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_DIV,
        S_UP_CMP,
        S_ROOT,
        S_LAST,
        S_DN,
        S_DN_CMP,
        S_DN_SW,
        S_FIN
    } t_state;

endpackage

// ----- design/dmhq_req_if.sv -----
// dmhq_req_if: request channel of the heap queue (valid, ready, request kind, key)
// depends on dmhq_pkg
interface dmhq_req_if
    import dmhq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [KEY_W-1:0] key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

// ----- design/dmhq_rsp_if.sv -----
// dmhq_rsp_if: result channel of the heap queue (valid, ready, max key, status, count)
// depends on dmhq_pkg
interface dmhq_rsp_if
    import dmhq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    max_key;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output max_key, output status, output count, input ready);
    modport sink   (input valid, input max_key, input status, input count, output ready);
endinterface

// ----- design/dary_max_heap_queue.sv -----
// d-ary max heap queue, one request at a time, keys in a single-port-read memory.
// insert: per level a divide finds the parent, which is read and compared; stops at the root.
// delete: root and last entry read, then per level the children read, compared, swap or stop;
// refused requests go straight to the result; next request taken once the result is loaded.
// reset: entry count zero, arity 2; the key memory is not cleared, no clearing pass.
// depends on dmhq_pkg, dmhq_req_if, dmhq_rsp_if
module dary_max_heap_queue
    import dmhq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dmhq_req_if.sink           i_req,
    dmhq_rsp_if.source         o_rsp,
    input  logic               i_cfg_we,
    input  logic [ARITY_W-1:0] i_cfg_wdata
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = AW + ARITY_W + 1;
    localparam int DCW = $clog2(AW + 1);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // key memory
    t_key heap_mem [CAPACITY];
    t_key r_rd_data;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_key          wr_data;

    t_state r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [ARITY_W-1:0] r_arity;
    logic [AW-1:0]      r_pos, n_pos;
    t_key               r_key, n_key;
    t_key               r_maxk, n_maxk;
    logic [STATUS_W-1:0] r_status, n_status;
    t_key               r_best_key, n_best_key;
    logic [AW-1:0]      r_best_idx, n_best_idx;
    logic               r_found, n_found;
    logic [AW-1:0]      r_child, n_child;
    logic [ARITY_W-1:0] r_kid, n_kid;
    logic [AW-1:0]      r_div_x, n_div_x;
    logic [AW-1:0]      r_div_q, n_div_q;
    logic [ARITY_W-1:0] r_div_rem, n_div_rem;
    logic [DCW-1:0]     r_div_cnt, n_div_cnt;

    logic                r_out_valid;
    t_key                r_out_maxk;
    logic [STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0]  r_out_count;

    logic               load_out;
    logic [ARITY_W-1:0] eff_d;
    logic [PW-1:0]      first_child;
    logic [ARITY_W:0]   div_tmp;
    logic               div_ge;
    logic [ARITY_W-1:0] div_rem_step;
    logic [AW-1:0]      div_q_step;

    always_comb begin
        if (r_arity < ARITY_MIN) begin
            eff_d = ARITY_MIN;
        end else if (r_arity > ARITY_MAX) begin
            eff_d = ARITY_MAX;
        end else begin
            eff_d = r_arity;
        end
    end

    assign first_child = PW'(eff_d) * PW'(r_pos) + PW'(1);

    // one restoring divide step: parent = (pos - 1) / d
    assign div_tmp      = {r_div_rem, r_div_x[AW-1]};
    assign div_ge       = div_tmp >= {1'b0, eff_d};
    assign div_rem_step = div_ge ? ARITY_W'(div_tmp - {1'b0, eff_d}) : div_tmp[ARITY_W-1:0];
    assign div_q_step   = (r_div_q << 1) | AW'(div_ge);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= heap_mem[rd_addr];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_key      = r_key;
        n_maxk     = r_maxk;
        n_status   = r_status;
        n_best_key = r_best_key;
        n_best_idx = r_best_idx;
        n_found    = r_found;
        n_child    = r_child;
        n_kid      = r_kid;
        n_div_x    = r_div_x;
        n_div_q    = r_div_q;
        n_div_rem  = r_div_rem;
        n_div_cnt  = r_div_cnt;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = r_pos;
        wr_data    = r_key;
        i_req.ready = 1'b0;
        load_out   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_maxk   = '0;
                    n_status = ST_OK;
                    if (i_req.req_type == REQ_INSERT) begin
                        if (r_count == CAP_C) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                            n_key   = t_key'(i_req.key);
                            n_state = S_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_count = r_count - CW'(1);
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = S_ROOT;
                        end
                    end
                end
            end
            S_UP: begin
                if (r_pos == '0) begin
                    wr_en   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_div_x   = r_pos - AW'(1);
                    n_div_q   = '0;
                    n_div_rem = '0;
                    n_div_cnt = DCW'(AW);
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                n_div_x   = r_div_x << 1;
                n_div_q   = div_q_step;
                n_div_rem = div_rem_step;
                n_div_cnt = r_div_cnt - DCW'(1);
                if (r_div_cnt == DCW'(1)) begin
                    rd_en   = 1'b1;
                    rd_addr = div_q_step;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                // r_div_q holds the parent index
                wr_en = 1'b1;
                if (r_key > r_rd_data) begin
                    wr_data = r_rd_data;
                    n_pos   = r_div_q;
                    n_state = S_UP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ROOT: begin
                n_maxk = r_rd_data;
                if (r_count == '0) begin
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_count[AW-1:0];
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_key   = r_rd_data;
                n_pos   = '0;
                n_state = S_DN;
            end
            S_DN: begin
                if (first_child >= PW'(r_count)) begin
                    wr_en   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_child = first_child[AW-1:0];
                    n_kid   = '0;
                    n_found = 1'b0;
                    rd_en   = 1'b1;
                    rd_addr = first_child[AW-1:0];
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                // first of equal largest children wins
                if (!r_found || r_rd_data > r_best_key) begin
                    n_best_key = r_rd_data;
                    n_best_idx = r_child;
                    n_found    = 1'b1;
                end
                if ((r_kid + ARITY_W'(1)) < eff_d && (CW'(r_child) + CW'(1)) < r_count) begin
                    n_child = r_child + AW'(1);
                    n_kid   = r_kid + ARITY_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_child + AW'(1);
                end else begin
                    n_state = S_DN_SW;
                end
            end
            S_DN_SW: begin
                wr_en = 1'b1;
                if (r_best_key > r_key) begin
                    wr_data = r_best_key;
                    n_pos   = r_best_idx;
                    n_state = S_DN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_arity     <= ARITY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_arity <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_maxk     <= n_maxk;
        r_status   <= n_status;
        r_best_key <= n_best_key;
        r_best_idx <= n_best_idx;
        r_found    <= n_found;
        r_child    <= n_child;
        r_kid      <= n_kid;
        r_div_x    <= n_div_x;
        r_div_q    <= n_div_q;
        r_div_rem  <= n_div_rem;
        r_div_cnt  <= n_div_cnt;
        if (load_out) begin
            r_out_maxk   <= r_maxk;
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_count);
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.max_key = r_out_maxk;
    assign o_rsp.status  = r_out_status;
    assign o_rsp.count   = r_out_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en && rd_addr == wr_addr))
        else $error("read and write of the same entry in one cycle");

    a_empty_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req.valid && i_req.req_type == REQ_DELETE && r_count == '0)
        |=> (r_state == S_FIN && r_status == ST_EMPTY))
        else $error("delete on empty not refused");

    a_child_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DN_CMP |-> CW'(r_child) < r_count)
        else $error("child read beyond held entries");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not held after load");
`endif

endmodule
